// ----- hdl/tcc_pkg.sv -----
// Shared types, constants and codes for the text console cursor writer.
`timescale 1ns / 1ps

package tcc_pkg;

  // Screen geometry defaults
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COLR_W = 4;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'd1;
  localparam logic [COLR_W-1:0] FG_RESET = 4'd15;
  localparam logic [COLR_W-1:0] BG_RESET = 4'd0;

  // Character codes and cell values
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0F20;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_e;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [ATTR_W-1:0] cell_color;
    logic [CHAR_W-1:0] character;
    cmd_e              command;
  } item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic              scrolled;
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
  } res_t;

endpackage

// ----- hdl/tcc_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tcc_ctrl.sv -----
// Sequencer: cursor, address unit and sweep counter driving the screen RAM.
`timescale 1ns / 1ps

module tcc_ctrl import tcc_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS),
  localparam int CW     = $clog2(CELLS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  item_t             item_i,
  input  logic [ATTR_W-1:0] attr_i,
  input  logic              out_free_i,
  output logic              ready_o,
  output logic              done_o,
  output res_t              res_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [CELL_W-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [CELL_W-1:0] ram_rdata_i
);

  localparam int FILL_BASE = (ROWS - 1) * COLUMNS;

  state_e           state_q, state_d;
  item_t            item_q, item_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             mv_vld_q, mv_vld_d;
  logic [AW-1:0]    mv_addr_q, mv_addr_d;
  logic             scr_q, scr_d;
  logic             onscr_q, onscr_d;

  logic [ROW_W-1:0] sel_row;
  logic [COL_W-1:0] sel_col;
  logic [CW-1:0]    cnt_back;
  logic             last_cell;
  logic             last_row;

  // Shared address unit: row * COLUMNS + column
  always_comb begin
    if (item_q.command == CMD_PUT) begin
      sel_row = row_q;
      sel_col = col_q;
    end else begin
      sel_row = item_q.row;
      sel_col = item_q.column;
    end
  end

  assign cnt_back  = cnt_q - CW'(COLUMNS);
  assign last_cell = (cnt_q == CW'(CELLS - 1));
  assign last_row  = (row_q == ROW_W'(ROWS - 1));

  // State and data registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      row_q    <= '0;
      col_q    <= '0;
      cnt_q    <= '0;
      mv_vld_q <= 1'b0;
      scr_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      col_q    <= col_d;
      cnt_q    <= cnt_d;
      mv_vld_q <= mv_vld_d;
      scr_q    <= scr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    addr_q    <= addr_d;
    mv_addr_q <= mv_addr_d;
    onscr_q   <= onscr_d;
  end

  // Next state and RAM control
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    row_d       = row_q;
    col_d       = col_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    mv_vld_d    = 1'b0;
    mv_addr_d   = mv_addr_q;
    scr_d       = scr_q;
    onscr_d     = onscr_q;
    ready_o     = 1'b0;
    done_o      = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = {attr_i, item_q.character};
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_q;

    unique case (state_q)
      // Power-up pass: every cell to white space on black
      ST_INIT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q[AW-1:0];
        ram_wdata_o = RESET_CELL;
        if (last_cell) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        ready_o = 1'b1;
        if (item_valid_i) begin
          item_d  = item_i;
          scr_d   = 1'b0;
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        addr_d  = AW'(sel_row * COLUMNS) + AW'(sel_col);
        onscr_d = (item_q.column < COLUMNS) && (item_q.row < ROWS);
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        unique case (item_q.command)
          CMD_PUT: begin
            if (item_q.character != CHAR_NEWLINE) begin
              ram_we_o = 1'b1;
            end
            if (item_q.character == CHAR_NEWLINE ||
                col_q == COL_W'(COLUMNS - 1)) begin
              col_d = '0;
              if (last_row) begin
                scr_d   = 1'b1;
                cnt_d   = CW'(COLUMNS);
                state_d = ST_SCROLL;
              end else begin
                row_d = row_q + 1'b1;
              end
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          CMD_WRITE: begin
            ram_we_o    = onscr_q;
            ram_wdata_o = {item_q.cell_color, item_q.character};
          end
          CMD_CLEAR: begin
            cnt_d   = '0;
            state_d = ST_FILL;
          end
          CMD_READ: begin
            ram_re_o = onscr_q;
          end
          default: ;
        endcase
      end
      // Move rows up: read one row below, write it in the next cycle
      ST_SCROLL: begin
        ram_re_o    = (cnt_q != CW'(CELLS));
        ram_raddr_o = cnt_q[AW-1:0];
        mv_vld_d    = ram_re_o;
        mv_addr_d   = cnt_back[AW-1:0];
        ram_we_o    = mv_vld_q;
        ram_waddr_o = mv_addr_q;
        ram_wdata_o = ram_rdata_i;
        if (ram_re_o) begin
          cnt_d = cnt_q + 1'b1;
        end else if (!mv_vld_q) begin
          cnt_d   = CW'(FILL_BASE);
          state_d = ST_FILL;
        end
      end
      // Blank sweep from cnt_q to the last cell
      ST_FILL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q[AW-1:0];
        ram_wdata_o = {attr_i, CHAR_SPACE};
        if (last_cell) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        done_o = out_free_i;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result fields
  always_comb begin
    res_o.cursor_row    = row_q;
    res_o.cursor_column = col_q;
    res_o.scrolled      = scr_q;
    res_o.cell_value    = (item_q.command == CMD_READ && onscr_q) ? ram_rdata_i : '0;
  end

endmodule

// ----- hdl/text_console_cursor_writer.sv -----
// Top level of the text console cursor writer: ports, config, output register.
//
//  channel  | dir | handshake                     | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | command, character, cell_color, column, row
//  m_axis   | out | m_axis_tvalid / m_axis_tready | cursor_row, cursor_column, cell_value, scrolled
//  cfg      | in  | cfg_we_i                      | fg_color (0), bg_color (1)
//
// Put char, direct write and read go through accept, address multiply, RAM access and result.
// A scroll adds row moves through the single RAM port pair plus a blank fill of the last row;
// a clear adds a blank fill of every cell.
// After reset a pass writes every cell; s_axis_tready stays low meanwhile.
// A result waiting on m_axis does not block the next item; it blocks only the one after.
`timescale 1ns / 1ps

module text_console_cursor_writer import tcc_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // command[1:0], character[9:2], cell_color[17:10], column[24:18], row[29:25], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // cursor_row[4:0], cursor_column[11:5], cell_value[27:12], scrolled[28], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [COLR_W-1:0]     cfg_wdata_i
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);

  logic [COLR_W-1:0] fg_q, bg_q;
  logic              out_vld_q, out_vld_d;
  res_t              out_q;
  item_t             item;
  res_t              res;
  logic              ready;
  logic              done;
  logic              out_free;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FG_COLOR: fg_q <= cfg_wdata_i;
        CFG_BG_COLOR: bg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign item          = item_t'(s_axis_tdata[ITEM_W-1:0]);
  assign s_axis_tready = ready;
  assign out_free      = !out_vld_q || m_axis_tready;

  tcc_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_i       (item),
    .attr_i       ({bg_q, fg_q}),
    .out_free_i   (out_free),
    .ready_o      (ready),
    .done_o       (done),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  tcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (done) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_q};

endmodule

// ----- hdl/tcc_checker.sv -----
// Port-level checker for the text console cursor writer, bound to the top level.
`timescale 1ns / 1ps

module tcc_checker import tcc_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  res_t res;
  assign res = res_t'(m_axis_tdata[$bits(res_t)-1:0]);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after an accepted item");

  // Cursor stays on screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.cursor_row < ROWS) && (res.cursor_column < COLUMNS))
    else $error("cursor off screen");

  // A scroll leaves the cursor at the start of the last row
  a_scroll_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.scrolled |->
      (res.cursor_row == ROW_W'(ROWS - 1)) && (res.cursor_column == '0))
    else $error("scroll left cursor elsewhere");

endmodule

bind text_console_cursor_writer tcc_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcc_checker (.*);
